### design/sorted_list_table_core_macros.svh
// ----------------------------------------------------------------------------
// Sorted list table assertion macros
// Shared property forms for the checker of the sorted list table.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_CORE_MACROS_SVH
`define SORTED_LIST_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted list table: same-cycle rule violated");

// Next-cycle implication, disabled while reset is high.
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted list table: next-cycle rule violated");

`endif

### design/slt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list table package
// Types, codes and constants shared by the cells, the core and the checker.
// ----------------------------------------------------------------------------
package slt_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int VALUE_W    = 32;
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int CAPACITY_DEFAULT = 16;

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 3'd0,
      REQ_SEARCH = 3'd1,
      REQ_DELETE = 3'd2,
      REQ_POP    = 3'd3,
      REQ_DUMP   = 3'd4
   } req_code_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   // Operation applied to every cell of the chain in one cycle.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_POP,
      CELL_ROTATE
   } cell_op_type;

   // Control broadcast from the sequencer to the cells.
   typedef struct packed {
      cell_op_type              op;
      logic signed [VALUE_W-1:0] key;
   } cell_ctrl_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_COMPARE,
      FSM_EXEC,
      FSM_DUMP
   } fsm_state_type;

endpackage

### design/slt_cell.sv
// ----------------------------------------------------------------------------
// Sorted list table cell
// Holds one entry, compares it against the broadcast key and moves data to
// and from its neighbours as the broadcast operation dictates.
// ----------------------------------------------------------------------------
module slt_cell
   import slt_pkg::*;
(
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic                      valid,
   input  logic                      wrap,
   input  logic                      left_stays,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic signed [VALUE_W-1:0] right_entry,
   input  logic signed [VALUE_W-1:0] head_entry,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      stays,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      stays_ff;
   logic                      stays_in;
   logic                      eq_ff;
   logic                      eq_in;

   // A cell stays in place when it holds a valid entry below the key; the
   // first cell that does not stay is the insertion or match position.
   always_comb begin
      entry_in = entry_ff;
      stays_in = stays_ff;
      eq_in    = eq_ff;
      unique case (ctrl.op)
         CELL_COMPARE: begin
            stays_in = valid && (entry_ff < ctrl.key);
            eq_in    = valid && (entry_ff == ctrl.key);
         end
         CELL_INSERT: begin
            if (!stays_ff) begin
               entry_in = left_stays ? ctrl.key : left_entry;
            end
         end
         CELL_REMOVE: begin
            if (!stays_ff) begin
               entry_in = right_entry;
            end
         end
         CELL_POP: begin
            entry_in = right_entry;
         end
         CELL_ROTATE: begin
            entry_in = wrap ? head_entry : right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Entry and comparison flags carry no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      stays_ff <= stays_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign stays = stays_ff;
   assign eq    = eq_ff;

endmodule

### design/sorted_list_table_core.sv
// ----------------------------------------------------------------------------
// Sorted list table core
// Keeps up to CAPACITY signed values in ascending order in a chain of cells
// and serves insert, search, delete, pop and dump requests.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_ready  | req_type, req_value
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_result_value, rsp_status,
//          |           |                      | rsp_entry_count, rsp_last
//
// One request is handled at a time: the idle state that accepts it, a compare
// state in which every cell checks its entry against the key, then an execute
// state that shifts the chain and loads the result register. A dump sends one
// further result per cycle while the result side accepts, rotating the chain.
// Stalls on the result side hold the execute and dump steps. Reset empties the
// table; entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_table_core
   import slt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [REQ_W-1:0]          req_type,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic                      rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   fsm_state_type             state_ff;
   fsm_state_type             state_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          idx_in;
   logic [REQ_W-1:0]          req_type_ff;
   logic signed [VALUE_W-1:0] key_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic signed [VALUE_W-1:0] rsp_value_in;
   status_type                rsp_status_ff;
   status_type                rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic [COUNT_W-1:0]        rsp_count_in;
   logic                      rsp_last_ff;
   logic                      rsp_last_in;

   cell_ctrl_type             cell_ctrl;
   cell_op_type               cell_op;
   logic signed [VALUE_W-1:0] entries [CAPACITY];
   logic [CAPACITY-1:0]       stays_w;
   logic [CAPACITY-1:0]       eq_w;
   logic                      found;
   logic                      out_free;
   logic [CNT_W-1:0]          count_dec;

   assign cell_ctrl = '{op: cell_op, key: key_ff};
   assign found     = |eq_w;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign count_dec = count_ff - CNT_W'(1);

   // Chain of cells; cell zero sees an always-staying left neighbour and the
   // last cell feeds itself from the right.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      left_stays_w;
      logic signed [VALUE_W-1:0] left_entry_w;
      logic signed [VALUE_W-1:0] right_entry_w;

      if (i == 0) begin : g_first
         assign left_stays_w = 1'b1;
         assign left_entry_w = key_ff;
      end else begin : g_inner
         assign left_stays_w = stays_w[i-1];
         assign left_entry_w = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry_w = entries[i];
      end else begin : g_body
         assign right_entry_w = entries[i+1];
      end

      slt_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .valid       (CNT_W'(i) < count_ff),
         .wrap        (CNT_W'(i) == count_dec),
         .left_stays  (left_stays_w),
         .left_entry  (left_entry_w),
         .right_entry (right_entry_w),
         .head_entry  (entries[0]),
         .entry       (entries[i]),
         .stays       (stays_w[i]),
         .eq          (eq_w[i])
      );
   end

   // Sequencer: next state, cell operation and result register contents.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cell_op       = CELL_HOLD;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_COMPARE;
            end
         end
         FSM_COMPARE: begin
            cell_op  = CELL_COMPARE;
            state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in      = FSM_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = key_ff;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               unique case (req_type_ff)
                  REQ_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cell_op       = CELL_INSERT;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  REQ_SEARCH: begin
                     rsp_status_in = found ? STATUS_OK : STATUS_NOT_FOUND;
                  end
                  REQ_DELETE: begin
                     if (found) begin
                        cell_op       = CELL_REMOVE;
                        count_in      = count_dec;
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cell_op       = CELL_POP;
                        count_in      = count_dec;
                        rsp_value_in  = entries[0];
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cell_op       = CELL_ROTATE;
                        rsp_value_in  = entries[0];
                        rsp_status_in = STATUS_OK;
                        rsp_last_in   = (count_ff == CNT_W'(1));
                        idx_in        = IDX_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           state_in = FSM_DUMP;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         FSM_DUMP: begin
            if (out_free) begin
               cell_op       = CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = entries[0];
               rsp_status_in = STATUS_OK;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = (idx_ff == IDX_W'(count_dec));
               idx_in        = idx_ff + IDX_W'(1);
               if (idx_ff == IDX_W'(count_dec)) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture and result payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_type_ff <= req_type;
         key_ff      <= req_value;
      end
      idx_ff        <= idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready        = (state_ff == FSM_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### design/slt_checker.sv
// ----------------------------------------------------------------------------
// Sorted list table checker
// Port-level assertions on the sorted list table, bound to the core module.
// ----------------------------------------------------------------------------
`include "sorted_list_table_core_macros.svh"

module slt_checker
   import slt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_result_value,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic [COUNT_W-1:0]        rsp_entry_count,
   input logic                      rsp_last
);

   localparam logic [COUNT_W-1:0] CAP_SHOWN = COUNT_W'(CAPACITY);

   // A stalled result transaction keeps its payload.
   `SLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status) && $stable(rsp_last))

   // One request at a time: after a request is taken the port closes.
   `SLT_ASSERT_NEXT(a_req_single, clock, reset, req_valid && req_ready, !req_ready)

   // Full is reported only when the table holds CAPACITY entries.
   `SLT_ASSERT_IMPL(a_full_count, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), rsp_entry_count == CAP_SHOWN)

   // Empty is reported only on an empty table and always ends the request.
   `SLT_ASSERT_IMPL(a_empty_last, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY), (rsp_entry_count == '0) && rsp_last)

   // Only a dump sends results before the last one, and those are all entries.
   `SLT_ASSERT_IMPL(a_dump_ok, clock, reset, rsp_valid && !rsp_last, rsp_status == STATUS_OK)

endmodule

bind sorted_list_table_core slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);

### tb/sv/sorted_list_table_core_test.sv
// ----------------------------------------------------------------------------
// Sorted list table core test
// Drives insert, search, delete, pop and dump transactions into the core,
// first from a short table of directed cases and then at random, and checks
// every result against a typed answer or a behavioural model kept here.
// ----------------------------------------------------------------------------
module sorted_list_table_core_test;
   import slt_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 435;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

   // Request codes that the core does not define.
   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      status_type                status;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } table_result_type;

   typedef struct {
      logic [REQ_W-1:0]          kind;
      logic signed [VALUE_W-1:0] operand;
      int                        repeats;
      bit                        typed;
      table_result_type          answer;
   } directed_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [REQ_W-1:0]          req_type  = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic                      rsp_last;

   // Model of the table and the results it still owes.
   logic signed [VALUE_W-1:0] model_entries [CAPACITY];
   int                        model_count = 0;
   table_result_type          awaited_results [$];

   int fault_count = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_mode  = 0;
   int stall_left  = 0;

   directed_row_type plan [25];

   sorted_list_table_core #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Close the gap left by a removed entry.
   task automatic drop_model_entry(input int pos);
      for (int i = pos; i + 1 < model_count; i++)
         model_entries[i] = model_entries[i + 1];
      model_count--;
   endtask

   // Apply one request to the table model and queue the results it causes.
   task automatic predict_table_request(input logic [REQ_W-1:0] kind,
                                        input logic signed [VALUE_W-1:0] operand);
      table_result_type outcome;
      int               pos;
      outcome.value  = operand;
      outcome.status = STATUS_NOT_FOUND;
      outcome.last   = 1'b1;
      case (kind)
         REQ_INSERT: begin
            if (model_count >= CAPACITY) begin
               outcome.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < model_count && model_entries[pos] < operand)
                  pos++;
               for (int i = model_count; i > pos; i--)
                  model_entries[i] = model_entries[i - 1];
               model_entries[pos] = operand;
               model_count++;
               outcome.status = STATUS_OK;
            end
         end
         REQ_SEARCH: begin
            for (int i = 0; i < model_count; i++)
               if (model_entries[i] == operand)
                  outcome.status = STATUS_OK;
         end
         REQ_DELETE: begin
            pos = -1;
            for (int i = model_count - 1; i >= 0; i--)
               if (model_entries[i] == operand)
                  pos = i;
            if (pos >= 0) begin
               drop_model_entry(pos);
               outcome.status = STATUS_OK;
            end
         end
         REQ_POP: begin
            if (model_count == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               outcome.value = model_entries[0];
               drop_model_entry(0);
               outcome.status = STATUS_OK;
            end
         end
         REQ_DUMP: begin
            if (model_count == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               // A dump reports the whole table in order, marking the final entry.
               for (int i = 0; i < model_count; i++) begin
                  outcome.value  = model_entries[i];
                  outcome.status = STATUS_OK;
                  outcome.count  = COUNT_W'(model_count);
                  outcome.last   = (i + 1 == model_count);
                  awaited_results.push_back(outcome);
               end
               return;
            end
         end
         default: ;
      endcase
      outcome.count = COUNT_W'(model_count);
      awaited_results.push_back(outcome);
   endtask

   // Offer one transaction at the current edge and wait for it to be taken.
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] operand,
                               input bit typed, input table_result_type answer);
      req_valid <= 1'b1;
      req_type  <= kind;
      req_value <= operand;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_table_request(kind, operand);
      // A typed answer stands in for the model's single result.
      if (typed) begin
         void'(awaited_results.pop_back());
         awaited_results.push_back(answer);
      end
   endtask

   // The sender works in bursts; a gap lowers valid between bursts.
   task automatic pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
      end
   endtask

   // The receiver switches between several stall patterns.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= (cycle_count % 3 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Compare every accepted result with the oldest one still owed.
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: value %0d status %0d count %0d last %0d",
                        rsp_result_value, rsp_status, rsp_entry_count, rsp_last);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_result_value !== want.value || rsp_status !== want.status ||
                rsp_entry_count !== want.count || rsp_last !== want.last) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch at cycle %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           cycle_count, want.value, want.status, want.count, want.last,
                           rsp_result_value, rsp_status, rsp_entry_count, rsp_last);
            end
         end
      end
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("sorted_list_table_core_test: done, errors");
      $finish;
   end

   initial begin
      int                        mix [3][5];
      int                        phase;
      int                        phase_left;
      int                        pick;
      logic [REQ_W-1:0]          kind;
      logic signed [VALUE_W-1:0] operand;
      table_result_type          none;

      none = '{32'sd0, STATUS_OK, 5'd0, 1'b0};

      // Empty-table cases, spare codes, extremes, duplicates and a full table.
      plan = '{
         '{REQ_POP,     32'sh1234_5678, 1, 1'b1, '{32'sh1234_5678, STATUS_EMPTY, 5'd0, 1'b1}},
         '{REQ_DUMP,    -32'sd5,        1, 1'b1, '{-32'sd5, STATUS_EMPTY, 5'd0, 1'b1}},
         '{REQ_DELETE,  32'sd7,         1, 1'b1, '{32'sd7, STATUS_NOT_FOUND, 5'd0, 1'b1}},
         '{REQ_SEARCH,  32'sd0,         1, 1'b1, '{32'sd0, STATUS_NOT_FOUND, 5'd0, 1'b1}},
         '{REQ_SPARE_A, 32'sd99,        1, 1'b1, '{32'sd99, STATUS_NOT_FOUND, 5'd0, 1'b1}},
         '{REQ_SPARE_C, -32'sd1,        1, 1'b1, '{-32'sd1, STATUS_NOT_FOUND, 5'd0, 1'b1}},
         '{REQ_INSERT,  VALUE_MAX,      1, 1'b1, '{VALUE_MAX, STATUS_OK, 5'd1, 1'b1}},
         '{REQ_INSERT,  VALUE_MIN,      1, 1'b1, '{VALUE_MIN, STATUS_OK, 5'd2, 1'b1}},
         '{REQ_INSERT,  32'sd0,         1, 1'b1, '{32'sd0, STATUS_OK, 5'd3, 1'b1}},
         '{REQ_INSERT,  -32'sd1,        1, 1'b1, '{-32'sd1, STATUS_OK, 5'd4, 1'b1}},
         '{REQ_INSERT,  32'sd0,         1, 1'b1, '{32'sd0, STATUS_OK, 5'd5, 1'b1}},
         '{REQ_SEARCH,  VALUE_MIN,      1, 1'b1, '{VALUE_MIN, STATUS_OK, 5'd5, 1'b1}},
         '{REQ_SEARCH,  32'sd1,         1, 1'b1, '{32'sd1, STATUS_NOT_FOUND, 5'd5, 1'b1}},
         '{REQ_DUMP,    32'sd0,         1, 1'b0, none},
         '{REQ_DELETE,  32'sd0,         1, 1'b1, '{32'sd0, STATUS_OK, 5'd4, 1'b1}},
         '{REQ_SEARCH,  32'sd0,         1, 1'b1, '{32'sd0, STATUS_OK, 5'd4, 1'b1}},
         '{REQ_DELETE,  32'sd12345,     1, 1'b1, '{32'sd12345, STATUS_NOT_FOUND, 5'd4, 1'b1}},
         '{REQ_SPARE_B, 32'sd55,        1, 1'b1, '{32'sd55, STATUS_NOT_FOUND, 5'd4, 1'b1}},
         '{REQ_POP,     32'sd77,        1, 1'b1, '{VALUE_MIN, STATUS_OK, 5'd3, 1'b1}},
         '{REQ_DUMP,    32'sd0,         1, 1'b0, none},
         '{REQ_INSERT,  32'sd100,      13, 1'b0, none},
         '{REQ_INSERT,  32'sd5,         1, 1'b1, '{32'sd5, STATUS_FULL, 5'd16, 1'b1}},
         '{REQ_DUMP,    32'sd0,         1, 1'b0, none},
         '{REQ_DELETE,  VALUE_MAX,      1, 1'b1, '{VALUE_MAX, STATUS_OK, 5'd15, 1'b1}},
         '{REQ_POP,     32'sd0,         1, 1'b1, '{-32'sd1, STATUS_OK, 5'd14, 1'b1}}
      };

      // Cumulative odds of insert, search, delete, pop and dump per phase:
      // filling, draining and mixed. Whatever is left goes to spare codes.
      mix = '{'{60, 72, 82, 90, 97}, '{15, 30, 55, 80, 94}, '{35, 52, 70, 85, 96}};
      phase      = 2;
      phase_left = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 12);

      // Directed table; repeated rows count their operand downwards.
      foreach (plan[n]) begin
         for (int k = 0; k < plan[n].repeats; k++) begin
            send_request(plan[n].kind, plan[n].operand - k, plan[n].typed, plan[n].answer);
            pace_sender();
         end
      end

      // Random transactions in filling, draining and mixed phases.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase      = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 50);
         end
         phase_left--;

         pick = $urandom_range(0, 99);
         if (pick < mix[phase][0])      kind = REQ_INSERT;
         else if (pick < mix[phase][1]) kind = REQ_SEARCH;
         else if (pick < mix[phase][2]) kind = REQ_DELETE;
         else if (pick < mix[phase][3]) kind = REQ_POP;
         else if (pick < mix[phase][4]) kind = REQ_DUMP;
         else kind = REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));

         // Small values collide often; stored values make searches and deletes hit.
         pick = $urandom_range(0, 99);
         if (pick < 35)
            operand = $signed($urandom_range(0, 8)) - 32'sd4;
         else if (pick < 60 && model_count > 0)
            operand = model_entries[$urandom_range(0, model_count - 1)];
         else if (pick < 75)
            case ($urandom_range(0, 3))
               0:       operand = VALUE_MIN;
               1:       operand = VALUE_MAX;
               2:       operand = -32'sd1;
               default: operand = 32'sd0;
            endcase
         else
            operand = $urandom;

         send_request(kind, operand, 1'b0, none);
         pace_sender();
      end

      if (req_valid === 1'b1)
         req_valid <= 1'b0;

      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("sorted_list_table_core_test: done, clean");
      else
         $display("sorted_list_table_core_test: done, errors");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/slt_pkg.sv
design/slt_cell.sv
design/sorted_list_table_core.sv
design/slt_checker.sv
tb/sv/sorted_list_table_core_test.sv
